// ===== design/sact_pkg.sv =====
// Shared types and constants for the set-associative cache tag model.
`default_nettype none
package sact_pkg;

	localparam int MAX_SETS_DEF = 1024;
	localparam int MAX_WAYS_DEF = 32;
	localparam int ADDR_W       = 32;
	localparam int CNT_W        = 32;
	localparam int RANK_W       = 5;
	localparam logic [RANK_W-1:0] RANK_MAX = 5'd31;
	localparam int META_W       = RANK_W + 2;
	localparam logic [15:0] LFSR_SEED = 16'h0001;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_POLICY  = 2'd0,
		CFG_OFFSET  = 2'd1,
		CFG_INDEX   = 2'd2,
		CFG_WAYS    = 2'd3
	} cfg_idx_t;

	localparam logic [1:0] POL_RANDOM = 2'd0;
	localparam logic [1:0] POL_LRU    = 2'd1;
	localparam logic [1:0] POL_PLRU   = 2'd2;

	localparam logic [1:0] POLICY_RST = POL_LRU;
	localparam logic [3:0] OFFSET_RST = 4'd6;
	localparam logic [3:0] INDEX_RST  = 4'd6;
	localparam logic [2:0] WAYS_RST   = 3'd2;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] address;
	} item_t;

	typedef struct packed {
		logic             hit;
		logic             evicted_dirty;
		logic [CNT_W-1:0] total_accesses;
		logic [CNT_W-1:0] read_accesses;
		logic [CNT_W-1:0] write_accesses;
		logic [CNT_W-1:0] total_misses;
		logic [CNT_W-1:0] read_misses;
		logic [CNT_W-1:0] write_misses;
		logic [CNT_W-1:0] dirty_evictions;
	} result_t;

	typedef struct packed {
		logic clear;
		logic capture;
		logic compare;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic clr_last;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== design/sact_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sact_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== design/sact_ctrl.sv =====
// Sequencer: reset clearing sweep, then read / compare / update per access.
`default_nettype none
module sact_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire sact_pkg::dp_stat_t stat,
	output sact_pkg::dp_cmd_t       cmd,
	output logic                    busy,
	output logic                    done
);
	typedef enum logic [4:0] {
		S_CLR  = 5'b00001,
		S_IDLE = 5'b00010,
		S_RD   = 5'b00100,
		S_CMP  = 5'b01000,
		S_UPD  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (stat.clr_last) state_d = S_IDLE;
			S_IDLE: if (start) state_d = S_RD;
			S_RD:   state_d = S_CMP;
			S_CMP:  state_d = S_UPD;
			S_UPD:  state_d = S_IDLE;
			default: state_d = S_CLR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == S_UPD);
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = done_q;
	assign cmd.clear   = (state_q == S_CLR);
	assign cmd.capture = (state_q == S_IDLE) && start;
	assign cmd.compare = (state_q == S_CMP);
	assign cmd.update  = (state_q == S_UPD);

`ifndef SYNTHESIS
	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == S_UPD))
		else $error("result strobe without update step");
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == S_RD))
		else $error("accepted access did not start a read");
	a_upd_follows_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $past(state_q == S_CMP))
		else $error("update without compare");
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |-> !cmd.capture)
		else $error("access taken during clearing sweep");
`endif
endmodule
`default_nettype wire

// ===== design/sact_dp.sv =====
// Datapath: config, address split, set row lookup, victim choice, row write-back, counters.
`default_nettype none
module sact_dp #(
	parameter int MAX_SETS = sact_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = sact_pkg::MAX_WAYS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire sact_pkg::dp_cmd_t                  cmd,
	output sact_pkg::dp_stat_t                      stat,
	input  wire sact_pkg::item_t                    item,
	input  wire logic                               cfg_we,
	input  wire logic [sact_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [sact_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output sact_pkg::result_t                       result
);
	localparam int SAW      = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
	localparam int WI       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int LW       = 1 << WI;
	localparam int SETB_MAX = $clog2(MAX_SETS + 1) - 1;
	localparam int WAYB_MAX = $clog2(MAX_WAYS + 1) - 1;
	localparam int KW       = WAYB_MAX + 2;
	localparam int TW       = sact_pkg::ADDR_W;
	localparam int MW       = sact_pkg::META_W;
	localparam int RW       = sact_pkg::RANK_W;

	// configuration
	logic [1:0] pol_q;
	logic [3:0] ob_q, ib_q;
	logic [2:0] wl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pol_q <= sact_pkg::POLICY_RST;
			ob_q  <= sact_pkg::OFFSET_RST;
			ib_q  <= sact_pkg::INDEX_RST;
			wl_q  <= sact_pkg::WAYS_RST;
		end else if (cfg_we) begin
			unique case (sact_pkg::cfg_idx_t'(cfg_index))
				sact_pkg::CFG_POLICY: pol_q <= cfg_wdata[1:0];
				sact_pkg::CFG_OFFSET: ob_q  <= cfg_wdata;
				sact_pkg::CFG_INDEX:  ib_q  <= cfg_wdata;
				sact_pkg::CFG_WAYS:   wl_q  <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// address split at capture
	logic [3:0]    ib_eff;
	logic [2:0]    wb_eff;
	logic [4:0]    sh;
	logic [TW-1:0] tag_c, set_c;

	always_comb begin
		ib_eff = (32'(ib_q) > SETB_MAX) ? 4'(SETB_MAX) : ib_q;
		wb_eff = (32'(wl_q) > WAYB_MAX) ? 3'(WAYB_MAX) : wl_q;
		sh     = 5'(ob_q) + 5'(ib_eff);
		tag_c  = item.address >> sh;
		set_c  = (item.address >> ob_q) & ((32'd1 << ib_eff) - 32'd1);
	end

	logic           mode_q;
	logic [TW-1:0]  tag_q;
	logic [SAW-1:0] set_q;
	logic [2:0]     wb_q;
	logic [1:0]     polc_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= item.mode;
			tag_q  <= tag_c;
			set_q  <= set_c[SAW-1:0];
			wb_q   <= wb_eff;
			polc_q <= pol_q;
		end
	end

	// clearing sweep address
	logic [SAW-1:0] clr_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end
	assign stat.clr_last = (32'(clr_q) == MAX_SETS - 1);

	// set rows
	logic [MAX_WAYS*TW-1:0] tag_rd, tag_wd;
	logic [MAX_WAYS*MW-1:0] meta_rd, meta_wd;
	logic [MAX_WAYS-1:0]    plru_rd, plru_wd;
	logic                   mem_we;
	logic [SAW-1:0]         waddr;

	assign mem_we = cmd.clear || cmd.update;
	assign waddr  = cmd.clear ? clr_q : set_q;

	sact_ram #(.WIDTH(MAX_WAYS*TW), .DEPTH(MAX_SETS)) u_tag_ram (
		.clk(clk), .we(cmd.update), .waddr(set_q), .wdata(tag_wd),
		.raddr(set_q), .rdata(tag_rd));
	sact_ram #(.WIDTH(MAX_WAYS*MW), .DEPTH(MAX_SETS)) u_meta_ram (
		.clk(clk), .we(mem_we), .waddr(waddr),
		.wdata(cmd.clear ? '0 : meta_wd), .raddr(set_q), .rdata(meta_rd));
	sact_ram #(.WIDTH(MAX_WAYS), .DEPTH(MAX_SETS)) u_plru_ram (
		.clk(clk), .we(mem_we), .waddr(waddr),
		.wdata(cmd.clear ? '0 : plru_wd), .raddr(set_q), .rdata(plru_rd));

	// row fields
	logic [MAX_WAYS-1:0] vld, drt, inuse;
	logic [RW-1:0]       rank [MAX_WAYS];
	logic [31:0]         ways32;

	always_comb begin
		ways32 = 32'd1 << wb_q;
		for (int i = 0; i < MAX_WAYS; i++) begin
			vld[i]   = meta_rd[i*MW];
			drt[i]   = meta_rd[i*MW+1];
			rank[i]  = meta_rd[i*MW+2 +: RW];
			inuse[i] = (i < ways32);
		end
	end

	// compare step
	logic          hit_c, inv_c;
	logic [WI-1:0] hitw_c, invw_c, lruw_c, plruw_c;
	logic [KW-1:0] k;
	// oldest-way search as a balanced tree; a tie keeps the lower way
	logic          nd_en   [2*LW];
	logic [RW-1:0] nd_rank [2*LW];
	logic [WI-1:0] nd_way  [2*LW];

	always_comb begin
		hit_c = 1'b0; hitw_c = '0;
		inv_c = 1'b0; invw_c = '0;
		for (int i = MAX_WAYS - 1; i >= 0; i--) begin
			if (inuse[i] && vld[i] && tag_rd[i*TW +: TW] == tag_q) begin
				hit_c = 1'b1; hitw_c = WI'(i);
			end
			if (inuse[i] && !vld[i]) begin
				inv_c = 1'b1; invw_c = WI'(i);
			end
		end
		nd_en[0] = 1'b0; nd_rank[0] = '0; nd_way[0] = '0;
		for (int i = 0; i < MAX_WAYS; i++) begin
			nd_en[LW+i]   = inuse[i];
			nd_rank[LW+i] = rank[i];
			nd_way[LW+i]  = WI'(i);
		end
		for (int i = MAX_WAYS; i < LW; i++) begin
			nd_en[LW+i]   = 1'b0;
			nd_rank[LW+i] = '0;
			nd_way[LW+i]  = '0;
		end
		for (int i = LW - 1; i >= 1; i--) begin
			if (nd_en[2*i+1] && (!nd_en[2*i] || nd_rank[2*i+1] > nd_rank[2*i])) begin
				nd_rank[i] = nd_rank[2*i+1]; nd_way[i] = nd_way[2*i+1];
			end else begin
				nd_rank[i] = nd_rank[2*i];   nd_way[i] = nd_way[2*i];
			end
			nd_en[i] = nd_en[2*i] || nd_en[2*i+1];
		end
		lruw_c = nd_way[1];
		k = '0;
		for (int l = 0; l < WAYB_MAX; l++) begin
			if (l < 32'(wb_q)) begin
				k = plru_rd[k[WI-1:0]] ? KW'(2*k + 2) : KW'(2*k + 1);
			end
		end
		plruw_c = WI'(k - KW'(ways32 - 32'd1));
	end

	logic          hit_q, inv_q;
	logic [WI-1:0] hitw_q, invw_q, lruw_q, plruw_q;

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			hit_q   <= hit_c;   hitw_q  <= hitw_c;
			inv_q   <= inv_c;   invw_q  <= invw_c;
			lruw_q  <= lruw_c;  plruw_q <= plruw_c;
		end
	end

	// update step
	logic [15:0]   lfsr_q;
	logic [WI-1:0] way, randw;
	logic          evict, evd, lfsr_adv;
	logic [RW-1:0] old;
	logic [KW-1:0] n, parent;

	always_comb begin
		randw = lfsr_q[WI-1:0] & WI'(ways32 - 32'd1);
		evict = !hit_q && !inv_q;
		case (polc_q)
			sact_pkg::POL_RANDOM: way = randw;
			sact_pkg::POL_PLRU:   way = plruw_q;
			default:              way = lruw_q;
		endcase
		if (hit_q) way = hitw_q;
		else if (inv_q) way = invw_q;
		lfsr_adv = evict && (polc_q == sact_pkg::POL_RANDOM);
		evd      = evict && drt[way];
		old      = vld[way] ? rank[way] : sact_pkg::RANK_MAX;

		meta_wd = meta_rd;
		for (int v = 0; v < MAX_WAYS; v++) begin
			if (inuse[v] && WI'(v) != way && vld[v] && rank[v] < old
					&& rank[v] < sact_pkg::RANK_MAX) begin
				meta_wd[v*MW+2 +: RW] = rank[v] + 1'b1;
			end
		end
		meta_wd[way*MW +: MW] = {{RW{1'b0}}, hit_q ? (drt[way] | mode_q) : mode_q, 1'b1};

		tag_wd = tag_rd;
		if (!hit_q) tag_wd[way*TW +: TW] = tag_q;

		plru_wd = plru_rd;
		n = KW'(way) + KW'(ways32 - 32'd1);
		for (int l = 0; l < WAYB_MAX; l++) begin
			if (l < 32'(wb_q)) begin
				parent = (n - 1'b1) >> 1;
				plru_wd[parent[WI-1:0]] = n[0];
				n = parent;
			end
		end
	end

	// counters and result
	logic [sact_pkg::CNT_W-1:0] c_tot, c_rd, c_wr, m_tot, m_rd, m_wr, c_dev;
	sact_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q <= sact_pkg::LFSR_SEED;
			c_tot <= '0; c_rd <= '0; c_wr <= '0;
			m_tot <= '0; m_rd <= '0; m_wr <= '0; c_dev <= '0;
		end else if (cmd.update) begin
			if (lfsr_adv) begin
				lfsr_q <= {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
			end
			c_tot <= c_tot + 1'b1;
			if (mode_q) c_wr <= c_wr + 1'b1;
			else        c_rd <= c_rd + 1'b1;
			if (!hit_q) begin
				m_tot <= m_tot + 1'b1;
				if (mode_q) m_wr <= m_wr + 1'b1;
				else        m_rd <= m_rd + 1'b1;
			end
			if (evd) c_dev <= c_dev + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_q.hit             <= hit_q;
			res_q.evicted_dirty   <= evd;
			res_q.total_accesses  <= c_tot + 1'b1;
			res_q.read_accesses   <= mode_q ? c_rd : c_rd + 1'b1;
			res_q.write_accesses  <= mode_q ? c_wr + 1'b1 : c_wr;
			res_q.total_misses    <= hit_q ? m_tot : m_tot + 1'b1;
			res_q.read_misses     <= (!hit_q && !mode_q) ? m_rd + 1'b1 : m_rd;
			res_q.write_misses    <= (!hit_q && mode_q) ? m_wr + 1'b1 : m_wr;
			res_q.dirty_evictions <= evd ? c_dev + 1'b1 : c_dev;
		end
	end
	assign result = res_q;

`ifndef SYNTHESIS
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0)
		else $error("lfsr locked at zero");
	a_evd_only_on_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && evd) |-> (!hit_q && !inv_q))
		else $error("dirty eviction flagged without eviction");
	a_hit_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && hit_q) |-> inuse[hitw_q])
		else $error("hit way outside ways in use");
`endif
endmodule
`default_nettype wire

// ===== design/set_assoc_cache_tag_model_core.sv =====
// Top level of the set-associative cache tag model.
// Usage:
//   Pulse start with item (mode, address) while busy is low; the access is
//   transferred on that edge. busy then stays high while the
//   set row is read, ways are compared and the victim chosen, and the rows,
//   replacement state and counters are written back.
//   done pulses for one cycle with result (hit, evicted_dirty, seven counters)
//   in the first cycle with busy low again; done and result are registered
//   from the update step. A new access may be started in that same cycle,
//   but not before the single set-row RAM read and write-back of the last one.
//   The receiver cannot stall; result holds until the next update step.
//   Config: cfg_we with cfg_index and cfg_wdata writes a register at once;
//   write only while no access is in flight.
//   Reset: arst_n clears config, counters and the LFSR, then a sweep over
//   all MAX_SETS set rows zeroes valid, dirty, rank and tree state with busy high.
`default_nettype none
module set_assoc_cache_tag_model_core #(
	parameter int MAX_SETS = sact_pkg::MAX_SETS_DEF,
	parameter int MAX_WAYS = sact_pkg::MAX_WAYS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire sact_pkg::item_t                 item,
	output logic                                 done,
	output sact_pkg::result_t                    result,
	input  wire logic                            cfg_we,
	input  wire logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [sact_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	sact_pkg::dp_cmd_t  cmd;
	sact_pkg::dp_stat_t stat;

	sact_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .stat(stat),
		.cmd(cmd), .busy(busy), .done(done));

	sact_dp #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat), .item(item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.result(result));
endmodule
`default_nettype wire
